// ----- design/sklc_pkg.sv -----
// Shared constants, codes and types for the skyline contour placer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sklc_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 256;
   localparam int COORD_BITS_DEFAULT   = 16;

   localparam int FIELD_BITS  = 16;
   localparam int LEVEL_BITS  = 20;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int REQ_BITS    = 72;
   localparam int RSP_BITS    = 40;

   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_PLACE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SEED  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic wr_en;
      logic full;
   } push_stat_type;

endpackage

`default_nettype wire

// ----- design/skyline_contour_placer.sv -----
// Skyline contour placer: two segment banks, the scan/merge sequencer and the result register.
// Depends on sklc_pkg, sklc_seg_ram and sklc_push.
`timescale 1ns / 1ps
`default_nettype none

// The contour of n segments lives in one of two RAM banks with one read port each.
// A place or seed transaction sweeps the active bank once to find the base level,
// then forms the top in ST_SCAN_END and ST_TOP and, unless the top overflows, a second sweep copies the
// segments left and right of the range into the spare bank, inserting the new
// segments. Clear, unused commands and rejected ranges go from ST_IDLE straight to
// ST_DONE. After reset the block writes the ground segment in ST_INIT before it takes
// its first transaction. The result register lets the next transaction start while a
// result still waits on the rsp side.
module skyline_contour_placer #(
   parameter int MAX_SEGMENTS = sklc_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int COORD_BITS   = sklc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // x_left[15:0], width[31:16], block_height[47:32], seed_top[67:48], zero[71:68]
   input  wire logic [sklc_pkg::REQ_BITS-1:0]     req_tdata,
   // command[1:0]
   input  wire logic [sklc_pkg::CMD_BITS-1:0]     req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // base_y[19:0], top_y[39:20]
   output logic      [sklc_pkg::RSP_BITS-1:0]     rsp_tdata,
   // status[1:0]
   output logic      [sklc_pkg::STATUS_BITS-1:0]  rsp_tuser
);

   localparam int SW = COORD_BITS + 1;
   localparam int LW = sklc_pkg::LEVEL_BITS;
   localparam int FW = sklc_pkg::FIELD_BITS;
   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int DW = SW + LW;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_INIT     = 11'b000_0000_0010,
      ST_SCAN     = 11'b000_0000_0100,
      ST_SCAN_END = 11'b000_0000_1000,
      ST_TOP      = 11'b000_0001_0000,
      ST_MERGE_LO = 11'b000_0010_0000,
      ST_INS_TOP  = 11'b000_0100_0000,
      ST_INS_AFT  = 11'b000_1000_0000,
      ST_MERGE_HI = 11'b001_0000_0000,
      ST_COMMIT   = 11'b010_0000_0000,
      ST_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // transaction fields
   logic [FW-1:0]                   x_in, w_in, bh_in;
   logic [LW-1:0]                   seed_in;
   logic                            req_acc, rng_err;
   logic [sklc_pkg::CMD_BITS-1:0]   cmd_ff;
   logic [SW-1:0]                   xl_ff, xr_ff;
   logic [FW-1:0]                   bh_ff;
   logic [LW-1:0]                   seed_ff;

   // contour bookkeeping
   logic                            active_ff;
   logic [CW-1:0]                   seg_count_ff;

   // sweep state
   logic [CW-1:0]                   rd_idx_ff;
   logic                            rd_vld_ff;
   logic                            rd_en;
   logic [DW-1:0]                   rd_data_a, rd_data_b, rd_data;
   logic [SW-1:0]                   rd_start;
   logic [LW-1:0]                   rd_level;
   logic [CW-1:0]                   klo_ff, khi_ff;
   logic [LW-1:0]                   h_after_ff;
   logic                            at_xr_ff;
   logic                            have_prev_ff;
   logic [SW-1:0]                   prev_start_ff;
   logic [LW-1:0]                   prev_level_ff;

   // working result
   logic [LW-1:0]                   best_ff, top_ff;
   logic [sklc_pkg::STATUS_BITS-1:0] status_ff;
   logic [LW:0]                     top_sum;

   // output register
   logic                            rsp_valid_ff;
   logic [LW-1:0]                   rsp_base_ff, rsp_top_ff;
   logic [sklc_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic                            rsp_load;

   // merge writer and banks
   logic                            push_clear, push_en;
   logic [SW-1:0]                   push_start;
   logic [LW-1:0]                   push_level;
   logic [AW-1:0]                   push_addr;
   logic [DW-1:0]                   push_data;
   logic [CW-1:0]                   push_cnt;
   sklc_pkg::push_stat_type         push_stat;
   logic                            ground_wr;
   logic                            wr_a_en, wr_b_en;
   logic [AW-1:0]                   wr_addr;
   logic [DW-1:0]                   wr_data;

   assign x_in    = req_tdata[15:0];
   assign w_in    = req_tdata[31:16];
   assign bh_in   = req_tdata[47:32];
   assign seed_in = req_tdata[67:48];

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign rng_err    = ((x_in >> COORD_BITS) != '0) || ((w_in >> COORD_BITS) != '0)
                       || (w_in == '0);

   assign rd_data  = active_ff ? rd_data_b : rd_data_a;
   assign rd_start = rd_data[DW-1:LW];
   assign rd_level = rd_data[LW-1:0];

   assign top_sum = (cmd_ff == sklc_pkg::CMD_PLACE) ? ((LW+1)'(best_ff) + (LW+1)'(bh_ff))
                                                    : (LW+1)'(seed_ff);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rd_en = 1'b0;
      unique case (state_ff)
         ST_SCAN, ST_MERGE_HI: rd_en = rd_idx_ff != seg_count_ff;
         ST_MERGE_LO:          rd_en = rd_idx_ff != klo_ff;
         default:              rd_en = 1'b0;
      endcase
   end

   always_comb begin
      push_en    = 1'b0;
      push_start = rd_start;
      push_level = rd_level;
      unique case (state_ff)
         ST_MERGE_LO, ST_MERGE_HI: push_en = rd_vld_ff;
         ST_INS_TOP: begin
            push_en    = 1'b1;
            push_start = xl_ff;
            push_level = top_ff;
         end
         ST_INS_AFT: begin
            push_en    = !at_xr_ff;
            push_start = xr_ff;
            push_level = h_after_ff;
         end
         default: push_en = 1'b0;
      endcase
   end

   assign push_clear = state_ff == ST_TOP;
   assign ground_wr  = (state_ff == ST_INIT)
                       || (req_acc && (req_tuser == sklc_pkg::CMD_CLEAR));
   assign wr_a_en    = ground_wr ? !active_ff : (push_stat.wr_en && active_ff);
   assign wr_b_en    = ground_wr ? active_ff : (push_stat.wr_en && !active_ff);
   assign wr_addr    = ground_wr ? '0 : push_addr;
   assign wr_data    = ground_wr ? '0 : push_data;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if ((req_tuser == sklc_pkg::CMD_PLACE || req_tuser == sklc_pkg::CMD_SEED)
                   && !rng_err) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_INIT:     state_in = ST_IDLE;
         ST_SCAN: begin
            if (rd_idx_ff == seg_count_ff && !rd_vld_ff) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: state_in = ST_TOP;
         ST_TOP:      state_in = top_sum[LW] ? ST_DONE : ST_MERGE_LO;
         ST_MERGE_LO: begin
            if (rd_idx_ff == klo_ff && !rd_vld_ff) state_in = ST_INS_TOP;
         end
         ST_INS_TOP:  state_in = ST_INS_AFT;
         ST_INS_AFT:  state_in = ST_MERGE_HI;
         ST_MERGE_HI: begin
            if (rd_idx_ff == seg_count_ff && !rd_vld_ff) state_in = ST_COMMIT;
         end
         ST_COMMIT:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         active_ff    <= 1'b0;
         seg_count_ff <= CW'(1);
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_en;
         if (rd_en) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end else if (state_ff == ST_IDLE || state_ff == ST_TOP) begin
            rd_idx_ff <= '0;
         end else if (state_ff == ST_INS_AFT) begin
            rd_idx_ff <= khi_ff;
         end
         if (ground_wr) begin
            seg_count_ff <= CW'(1);
         end
         if (state_ff == ST_COMMIT && !push_stat.full) begin
            active_ff    <= !active_ff;
            seg_count_ff <= push_cnt;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff     <= req_tuser;
         xl_ff      <= SW'(x_in);
         xr_ff      <= SW'(x_in) + SW'(w_in);
         bh_ff      <= bh_in;
         seed_ff    <= seed_in;
         best_ff    <= '0;
         top_ff     <= '0;
         status_ff  <= ((req_tuser == sklc_pkg::CMD_PLACE || req_tuser == sklc_pkg::CMD_SEED)
                        && rng_err) ? sklc_pkg::STATUS_RANGE : sklc_pkg::STATUS_OK;
         klo_ff       <= '0;
         khi_ff       <= '0;
         h_after_ff   <= '0;
         at_xr_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
      end
      if (state_ff == ST_SCAN && rd_vld_ff) begin
         if (rd_start < xr_ff) begin
            h_after_ff <= rd_level;
            khi_ff     <= khi_ff + 1'b1;
         end
         if (rd_start < xl_ff) klo_ff <= klo_ff + 1'b1;
         if (rd_start == xr_ff) at_xr_ff <= 1'b1;
         if (have_prev_ff && prev_start_ff < xr_ff && rd_start > xl_ff
             && prev_level_ff > best_ff) begin
            best_ff <= prev_level_ff;
         end
         prev_start_ff <= rd_start;
         prev_level_ff <= rd_level;
         have_prev_ff  <= 1'b1;
      end
      if (state_ff == ST_SCAN_END && have_prev_ff && prev_start_ff < xr_ff
          && prev_level_ff > best_ff) begin
         best_ff <= prev_level_ff;
      end
      if (state_ff == ST_TOP) begin
         top_ff <= top_sum[LW-1:0];
         if (top_sum[LW]) status_ff <= sklc_pkg::STATUS_RANGE;
      end
      if (state_ff == ST_COMMIT && push_stat.full) begin
         status_ff <= sklc_pkg::STATUS_FULL;
      end
      if (rsp_load) begin
         rsp_base_ff   <= best_ff;
         rsp_top_ff    <= top_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_top_ff, rsp_base_ff};
   assign rsp_tuser  = rsp_status_ff;

   sklc_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .DW    (DW)
   ) u_bank_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data_a)
   );

   sklc_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .DW    (DW)
   ) u_bank_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data_b)
   );

   sklc_push #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .SW           (SW)
   ) u_push (
      .clock      (clock),
      .reset      (reset),
      .clear      (push_clear),
      .push_en    (push_en),
      .push_start (push_start),
      .push_level (push_level),
      .wr_addr    (push_addr),
      .wr_data    (push_data),
      .cnt        (push_cnt),
      .stat       (push_stat)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff != '0 && seg_count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");

   a_swap_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(active_ff) |-> $past(state_ff == ST_COMMIT && !push_stat.full))
      else $error("bank swap outside a successful commit");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_stat.wr_en |-> push_cnt != CW'(MAX_SEGMENTS))
      else $error("merge write beyond table");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_vld_ff && !push_stat.wr_en)
      else $error("bank traffic while idle");

endmodule

`default_nettype wire

// ----- design/sklc_seg_ram.sv -----
// Segment table bank: simple dual-port RAM, one write and one registered read port.
// Depends on sklc_pkg for its defaults; instantiated twice by skyline_contour_placer.
`timescale 1ns / 1ps
`default_nettype none

module sklc_seg_ram #(
   parameter  int DEPTH = sklc_pkg::MAX_SEGMENTS_DEFAULT,
   parameter  int DW    = sklc_pkg::COORD_BITS_DEFAULT + 1 + sklc_pkg::LEVEL_BITS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/sklc_push.sv -----
// Merge writer: appends segments to the spare bank, folding equal adjacent levels.
// Depends on sklc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sklc_push #(
   parameter  int MAX_SEGMENTS = sklc_pkg::MAX_SEGMENTS_DEFAULT,
   parameter  int SW           = sklc_pkg::COORD_BITS_DEFAULT + 1,
   localparam int AW           = $clog2(MAX_SEGMENTS),
   localparam int CW           = $clog2(MAX_SEGMENTS + 1),
   localparam int DW           = SW + sklc_pkg::LEVEL_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            clear,
   input  wire logic                            push_en,
   input  wire logic [SW-1:0]                   push_start,
   input  wire logic [sklc_pkg::LEVEL_BITS-1:0] push_level,
   output logic      [AW-1:0]                   wr_addr,
   output logic      [DW-1:0]                   wr_data,
   output logic      [CW-1:0]                   cnt,
   output sklc_pkg::push_stat_type              stat
);

   logic [CW-1:0]                   cnt_ff;
   logic                            full_ff;
   logic [sklc_pkg::LEVEL_BITS-1:0] last_level_ff;
   logic                            merge;
   logic                            room;

   assign merge = (cnt_ff != '0) && (last_level_ff == push_level);
   assign room  = cnt_ff != CW'(MAX_SEGMENTS);

   always_comb begin
      stat.wr_en = push_en && !merge && room;
      stat.full  = full_ff;
   end

   assign wr_addr = cnt_ff[AW-1:0];
   assign wr_data = {push_start, push_level};
   assign cnt     = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         cnt_ff  <= '0;
         full_ff <= 1'b0;
      end else if (push_en && !merge) begin
         if (room) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else begin
            full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && !merge && room) begin
         last_level_ff <= push_level;
      end
   end

endmodule

`default_nettype wire

// ----- bench/tb_skyline_contour_placer.sv -----
// Self-checking bench for skyline_contour_placer: directed rows, then random command runs.
// Depends on sklc_pkg and the design sources; keeps its own model of the contour.
`timescale 1ns / 1ps

module tb_skyline_contour_placer;

   localparam int CMW             = sklc_pkg::CMD_BITS;
   localparam int FW              = sklc_pkg::FIELD_BITS;
   localparam int LW              = sklc_pkg::LEVEL_BITS;
   localparam int STW             = sklc_pkg::STATUS_BITS;
   localparam int SEG_DEPTH       = sklc_pkg::MAX_SEGMENTS_DEFAULT;
   localparam int ITEMS_PER_PHASE = 430;
   localparam int FILL_SEEDS      = 140;
   localparam int HOLD_CYCLES     = 3000;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int DRAIN_CYCLES    = 600;
   localparam logic [CMW-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMW-1:0] command;
      logic [FW-1:0]  x_left;
      logic [FW-1:0]  width;
      logic [FW-1:0]  block_height;
      logic [LW-1:0]  seed_top;
   } req_item_type;

   typedef struct packed {
      logic [LW-1:0]  base_y;
      logic [LW-1:0]  top_y;
      logic [STW-1:0] status;
   } placement_type;

   typedef struct {
      req_item_type  item;
      bit            typed;
      placement_type want;
   } row_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sklc_pkg::REQ_BITS-1:0]    req_tdata  = '0;
   logic [CMW-1:0]                   req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sklc_pkg::RSP_BITS-1:0]    rsp_tdata;
   logic [STW-1:0]                   rsp_tuser;

   // contour model
   logic [FW:0]   seg_x [SEG_DEPTH];
   logic [LW-1:0] seg_h [SEG_DEPTH];
   int            seg_n;
   logic [FW:0]   new_x [SEG_DEPTH+2];
   logic [LW-1:0] new_h [SEG_DEPTH+2];
   int            new_n;

   placement_type result_q [$];
   row_type       directed_rows [$];
   int            mismatches     = 0;
   int            send_idle_pct  = 0;
   int            recv_idle_pct  = 0;
   int            stall_requests = 0;
   int            stall_seen     = 0;
   int            hold_left      = 0;
   int            idle_cycles    = 0;

   skyline_contour_placer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic void push_segment(logic [FW:0] s, logic [LW-1:0] l);
      if (new_n > 0 && new_h[new_n-1] == l) return;
      if (new_n < SEG_DEPTH + 2) begin
         new_x[new_n] = s;
         new_h[new_n] = l;
         new_n++;
      end
   endfunction

   function automatic placement_type place_on_contour(req_item_type it);
      placement_type r;
      logic [FW:0]   xl;
      logic [FW:0]   xr;
      logic [LW:0]   top;
      logic [LW-1:0] best;
      logic [LW-1:0] h_after;
      bit            at_xr;
      bit            is_last;
      r = '0;
      if (it.command == sklc_pkg::CMD_CLEAR) begin
         seg_n    = 1;
         seg_x[0] = '0;
         seg_h[0] = '0;
      end else if (it.command == sklc_pkg::CMD_PLACE || it.command == sklc_pkg::CMD_SEED) begin
         if (it.width == 0) begin
            r.status = sklc_pkg::STATUS_RANGE;
         end else begin
            xl   = {1'b0, it.x_left};
            xr   = xl + {1'b0, it.width};
            best = '0;
            for (int i = 0; i < seg_n; i++) begin
               is_last = (i + 1 >= seg_n);
               if (seg_x[i] < xr && (is_last || seg_x[i+1] > xl) && seg_h[i] > best)
                  best = seg_h[i];
            end
            r.base_y = best;
            top = (it.command == sklc_pkg::CMD_PLACE) ? {1'b0, best} + (LW+1)'(it.block_height)
                                                      : {1'b0, it.seed_top};
            r.top_y = top[LW-1:0];
            if (top[LW]) begin
               r.status = sklc_pkg::STATUS_RANGE;
            end else begin
               h_after = '0;
               at_xr   = 1'b0;
               for (int i = 0; i < seg_n; i++) begin
                  if (seg_x[i] < xr) h_after = seg_h[i];
                  if (seg_x[i] == xr) at_xr = 1'b1;
               end
               new_n = 0;
               for (int i = 0; i < seg_n; i++)
                  if (seg_x[i] < xl) push_segment(seg_x[i], seg_h[i]);
               push_segment(xl, top[LW-1:0]);
               if (!at_xr) push_segment(xr, h_after);
               for (int i = 0; i < seg_n; i++)
                  if (seg_x[i] >= xr) push_segment(seg_x[i], seg_h[i]);
               if (new_n > SEG_DEPTH) begin
                  r.status = sklc_pkg::STATUS_FULL;
               end else begin
                  for (int i = 0; i < new_n; i++) begin
                     seg_x[i] = new_x[i];
                     seg_h[i] = new_h[i];
                  end
                  seg_n = new_n;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic req_item_type make_item(logic [CMW-1:0] cmd, logic [15:0] x,
                                              logic [15:0] w, logic [15:0] bh,
                                              logic [19:0] top);
      req_item_type it;
      it.command      = cmd;
      it.x_left       = x;
      it.width        = w;
      it.block_height = bh;
      it.seed_top     = top;
      return it;
   endfunction

   // mostly local placements so blocks stack and interact
   function automatic req_item_type run_item();
      req_item_type it;
      it.command = ($urandom_range(99) < 60) ? sklc_pkg::CMD_PLACE : sklc_pkg::CMD_SEED;
      if ($urandom_range(19) == 0) begin
         it.x_left = 16'($urandom);
         it.width  = 16'($urandom_range(1, 65535));
      end else begin
         it.x_left = 16'($urandom_range(0, 400));
         it.width  = 16'($urandom_range(1, 80));
      end
      it.block_height = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      it.seed_top     = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 300));
      return it;
   endfunction

   function automatic req_item_type noise_item();
      req_item_type it;
      it.command      = 2'($urandom_range(0, 3));
      it.x_left       = 16'($urandom);
      it.width        = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
      it.block_height = 16'($urandom);
      it.seed_top     = 20'($urandom);
      return it;
   endfunction

   task automatic add_row(input req_item_type item, input bit typed,
                          input placement_type want);
      row_type row;
      row.item  = item;
      row.typed = typed;
      row.want  = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // entered and left at a falling edge
   task automatic send_item(input req_item_type item, input bit typed,
                            input placement_type want);
      placement_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.command;
      req_tdata  <= {4'b0, item.seed_top, item.block_height, item.width, item.x_left};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = place_on_contour(item);
      result_q.insert(result_q.size(), typed ? want : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_seen != stall_requests) begin
         stall_seen <= stall_requests;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      placement_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (result_q.size() == 0) begin
            $error("unexpected result: base_y %0h top_y %0h status %0d",
                   rsp_tdata[19:0], rsp_tdata[39:20], rsp_tuser);
            mismatches++;
         end else begin
            want = result_q.pop_front();
            if (rsp_tdata[19:0] !== want.base_y) begin
               $error("base_y: expected %0h, got %0h", want.base_y, rsp_tdata[19:0]);
               mismatches++;
            end
            if (rsp_tdata[39:20] !== want.top_y) begin
               $error("top_y: expected %0h, got %0h", want.top_y, rsp_tdata[39:20]);
               mismatches++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int           roll;
      int           n;
      int           counted;
      bit           filled;
      req_item_type it;

      seg_n    = 1;
      seg_x[0] = '0;
      seg_h[0] = '0;

      add_row(make_item(sklc_pkg::CMD_PLACE, 16'h0, 16'h1, 16'h0, 20'h0), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});
      add_row(make_item(sklc_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 20'h0), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});
      add_row(make_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'h5, 16'h0, 16'h3, 20'h0), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_RANGE});
      add_row(make_item(sklc_pkg::CMD_SEED, 16'h5, 16'h0, 16'h0, 20'h7), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_RANGE});
      add_row(make_item(sklc_pkg::CMD_SEED, 16'h0, 16'hFFFF, 16'h0, 20'hFFFFF), 1,
              '{20'h0, 20'hFFFFF, sklc_pkg::STATUS_OK});
      // top wraps past the level width
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'hA, 16'h5, 16'h1, 20'h0), 1,
              '{20'hFFFFF, 20'h0, sklc_pkg::STATUS_RANGE});
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'hFFFE, 16'h4, 16'hFFFF, 20'h0), 0, '0);
      add_row(make_item(sklc_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 20'h0), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'h0), 1,
              '{20'h0, 20'hFFFF, sklc_pkg::STATUS_OK});
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'hFFFF, 16'h1, 16'h5, 20'h0), 0, '0);
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'd100, 16'd50, 16'd7, 20'h0), 0, '0);
      // abuts the previous block: its level must not count
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'd150, 16'd10, 16'd3, 20'h0), 0, '0);
      // right edge lands on an existing boundary
      add_row(make_item(sklc_pkg::CMD_SEED, 16'd120, 16'd30, 16'h0, 20'd9), 0, '0);
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'h0, 16'hFFFF, 16'hFFFF, 20'h0), 0, '0);
      add_row(make_item(sklc_pkg::CMD_SEED, 16'hAAAA, 16'h5555, 16'h5555, 20'h55555), 0, '0);
      add_row(make_item(sklc_pkg::CMD_PLACE, 16'h5555, 16'hAAAA, 16'hAAAA, 20'h0), 0, '0);
      add_row(make_item(sklc_pkg::CMD_SEED, 16'h0, 16'h1, 16'h0, 20'hAAAAA), 0, '0);
      add_row(make_item(CMD_UNUSED, 16'h1234, 16'h0, 16'h5678, 20'h9ABCD), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});
      add_row(make_item(sklc_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 20'h0), 1,
              '{20'h0, 20'h0, sklc_pkg::STATUS_OK});

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 7;
      recv_idle_pct = 48;
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 7 : 0;
         if (phase == 0) stall_requests++;
         counted = 0;
         filled  = 1'b0;
         while (counted < ITEMS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (!filled && counted >= ITEMS_PER_PHASE / 3) begin
               // narrow seeds with rising tops until the table overflows
               send_item(make_item(sklc_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 20'h0), 0, '0);
               for (int k = 0; k < FILL_SEEDS; k++)
                  send_item(make_item(sklc_pkg::CMD_SEED, 16'(k * 8), 16'd3, 16'($urandom),
                                      20'(k + 1)), 0, '0);
               for (int k = 0; k < 6; k++)
                  send_item(run_item(), 0, '0);
               counted += FILL_SEEDS + 7;
               filled   = 1'b1;
            end else if (roll < 80) begin
               send_item(make_item(sklc_pkg::CMD_CLEAR, 16'h0, 16'h0, 16'h0, 20'h0), 0, '0);
               n = $urandom_range(5, 40);
               for (int k = 0; k < n; k++)
                  send_item(run_item(), 0, '0);
               counted += n + 1;
            end else begin
               n = $urandom_range(1, 4);
               for (int k = 0; k < n; k++) begin
                  it = noise_item();
                  send_item(it, 0, '0);
                  if (it.command != CMD_UNUSED) counted++;
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
